// ----- rtl/b6t_pkg.sv -----
// Package of the brick to six tetrahedra node numbering block: widths, codes and corner table.
package b6t_pkg;

    localparam int CELL_W        = 8;
    localparam int NODE_W        = 25;
    localparam int ROW_W         = 9;
    localparam int PLANE_W       = 17;
    localparam int TETRA_W       = 3;
    localparam int CORNER_IDX_W  = 3;
    localparam int TETRAS        = 6;
    localparam int CORNERS       = 8;
    localparam int MAX_CELLS_DEF = 255;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Z = 2'd2;

    localparam logic [TETRA_W-1:0] LAST_TETRA = TETRA_W'(TETRAS - 1);

    typedef logic [NODE_W-1:0] t_node;

    // Grid configuration as seen by the datapath, with the corner offsets
    // from the base node held in corner order.
    typedef struct packed {
        logic [CELL_W-1:0]         cells_x;
        logic [CELL_W-1:0]         cells_y;
        logic [CELL_W-1:0]         cells_z;
        logic [ROW_W-1:0]          row;
        logic [PLANE_W-1:0]        plane;
        t_node [CORNERS-1:0]       offset;
    } t_grid;

    // Corner index of position m (0..3) of tetrahedron t (0..5).
    function automatic logic [CORNER_IDX_W-1:0] tetra_corner(
        input logic [TETRA_W-1:0] t,
        input logic [1:0]         m
    );
        logic [CORNER_IDX_W-1:0] c;
        c = 3'd7;
        case (m)
            2'd0: begin
                case (t)
                    3'd0, 3'd1: c = 3'd0;
                    default:    c = 3'd1;
                endcase
            end
            2'd1: begin
                case (t)
                    3'd0, 3'd1: c = 3'd1;
                    3'd2, 3'd3: c = 3'd2;
                    3'd4:       c = 3'd5;
                    default:    c = 3'd6;
                endcase
            end
            2'd2: begin
                case (t)
                    3'd0, 3'd2: c = 3'd3;
                    3'd1, 3'd4: c = 3'd4;
                    3'd3:       c = 3'd6;
                    default:    c = 3'd5;
                endcase
            end
            default: c = 3'd7;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/brick_to_six_tetra_node_ids_core.sv -----
// Top level of the brick to six tetrahedra node numbering block.
//
//  Channel  | Direction | Handshake                     | Payload
//  ---------+-----------+-------------------------------+---------------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready | tdata: cell x, y, z
//  m_axis   | out       | m_axis_tvalid / m_axis_tready | tdata: tetra, corners; tlast; tuser
//  cfg      | in        | i_cfg_we                      | i_cfg_idx, i_cfg_wdata
//
// Each brick gives six results, one per cycle through the single output register while the
// output does not stall; the next brick is taken in the cycle its last result is taken.
// A brick accepted into the first pipeline stage moves on through the second and third
// pipeline stages into the corner register, where its first result appears; up to four
// bricks are in flight.
// Reset sets every grid size to one and empties the pipeline; there is no clearing pass.
// When m_axis_tready is low the shown result holds and the input stages fill, then
// s_axis_tready falls.
module brick_to_six_tetra_node_ids_core
    import b6t_pkg::*;
#(
    parameter int MAX_CELLS = MAX_CELLS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CELL_W-1:0]    i_cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [23:0]          s_axis_tdata,   // cell_x, cell_y, cell_z
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [103:0]         m_axis_tdata,   // tetra_number, corner_a..corner_d, zero pad
    output logic                 m_axis_tlast,   // final_tetra
    output logic                 m_axis_tuser    // range_error
);

    t_grid              w_grid;
    logic               w_c_valid, w_c_ready, w_c_err;
    t_node              w_c_base;
    logic [TETRA_W-1:0] w_tetra;
    t_node [3:0]        w_corner;

    b6t_cfg #(
        .MAX_CELLS (MAX_CELLS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_grid      (w_grid)
    );

    b6t_calc u_calc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_grid   (w_grid),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_cell_x (s_axis_tdata[7:0]),
        .i_cell_y (s_axis_tdata[15:8]),
        .i_cell_z (s_axis_tdata[23:16]),
        .o_valid  (w_c_valid),
        .i_ready  (w_c_ready),
        .o_base   (w_c_base),
        .o_err    (w_c_err)
    );

    b6t_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_grid   (w_grid),
        .i_valid  (w_c_valid),
        .o_ready  (w_c_ready),
        .i_base   (w_c_base),
        .i_err    (w_c_err),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_tetra  (w_tetra),
        .o_corner (w_corner),
        .o_last   (m_axis_tlast),
        .o_err    (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, w_corner[3], w_corner[2], w_corner[1], w_corner[0], w_tetra};

endmodule

// ----- rtl/b6t_cfg.sv -----
// Grid size registers with saturation, and the derived row, plane and corner offsets.
module b6t_cfg
    import b6t_pkg::*;
#(
    parameter int MAX_CELLS = MAX_CELLS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CELL_W-1:0]    i_cfg_wdata,
    output t_grid                o_grid
);

    logic [CELL_W-1:0]   r_cells_x, r_cells_y, r_cells_z;
    logic [CELL_W-1:0]   w_clamped;
    logic [ROW_W-1:0]    r_row;
    logic [PLANE_W-1:0]  r_plane;
    logic [ROW_W-1:0]    w_row_y, w_row_z;
    logic [2*ROW_W-1:0]  w_plane_full;
    t_node [CORNERS-1:0] r_offset, n_offset;
    t_node               w_row_n, w_plane_n;

    always_comb begin
        if (32'(i_cfg_wdata) > MAX_CELLS) begin
            w_clamped = CELL_W'(MAX_CELLS);
        end else begin
            w_clamped = i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells_x <= CELL_W'(1);
            r_cells_y <= CELL_W'(1);
            r_cells_z <= CELL_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CELLS_X: r_cells_x <= w_clamped;
                CFG_CELLS_Y: r_cells_y <= w_clamped;
                CFG_CELLS_Z: r_cells_z <= w_clamped;
                default: ;
            endcase
        end
    end

    assign w_row_y      = ROW_W'(r_cells_y) + ROW_W'(1);
    assign w_row_z      = ROW_W'(r_cells_z) + ROW_W'(1);
    assign w_plane_full = (2*ROW_W)'(w_row_y) * (2*ROW_W)'(w_row_z);

    // Row and plane are registered from the size registers and the corner offsets from row and
    // plane; an item reaches the stages that use them only after these have settled.
    always_ff @(posedge i_clk) begin
        r_row    <= w_row_z;
        r_plane  <= w_plane_full[PLANE_W-1:0];
        r_offset <= n_offset;
    end

    assign w_row_n   = NODE_W'(r_row);
    assign w_plane_n = NODE_W'(r_plane);

    always_comb begin
        n_offset[0] = w_plane_n + w_row_n + NODE_W'(1);
        n_offset[1] = w_row_n + NODE_W'(1);
        n_offset[2] = NODE_W'(1);
        n_offset[3] = w_plane_n + NODE_W'(1);
        n_offset[4] = w_plane_n + w_row_n;
        n_offset[5] = w_row_n;
        n_offset[6] = '0;
        n_offset[7] = w_plane_n;
    end

    always_comb begin
        o_grid.cells_x = r_cells_x;
        o_grid.cells_y = r_cells_y;
        o_grid.cells_z = r_cells_z;
        o_grid.row     = r_row;
        o_grid.plane   = r_plane;
        o_grid.offset  = r_offset;
    end

endmodule

// ----- rtl/b6t_calc.sv -----
// Three-stage elastic pipeline from cell index to base node number and range flag.
module b6t_calc
    import b6t_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_grid             i_grid,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CELL_W-1:0] i_cell_x,
    input  logic [CELL_W-1:0] i_cell_y,
    input  logic [CELL_W-1:0] i_cell_z,
    output logic              o_valid,
    input  logic              i_ready,
    output t_node             o_base,
    output logic              o_err
);

    logic              r1_v, r2_v, r3_v;
    logic              w_rdy1, w_rdy2, w_rdy3;
    logic [CELL_W-1:0] r1_cx, r1_cy, r1_cz;
    logic              r1_err, r2_err, r3_err;
    t_node             r2_px, r2_q, r3_base;
    t_node             n_px, n_q;
    logic              n_err;

    assign w_rdy3  = !r3_v || i_ready;
    assign w_rdy2  = !r2_v || w_rdy3;
    assign w_rdy1  = !r1_v || w_rdy2;
    assign o_ready = w_rdy1;

    assign n_err = (i_cell_x >= i_grid.cells_x) || (i_cell_y >= i_grid.cells_y)
                || (i_cell_z >= i_grid.cells_z);

    assign n_px = NODE_W'(r1_cx) * NODE_W'(i_grid.plane);
    assign n_q  = NODE_W'(r1_cy) * NODE_W'(i_grid.row) + NODE_W'(r1_cz) + NODE_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (w_rdy1) r1_v <= i_valid;
            if (w_rdy2) r2_v <= r1_v;
            if (w_rdy3) r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r1_cx  <= i_cell_x;
            r1_cy  <= i_cell_y;
            r1_cz  <= i_cell_z;
            r1_err <= n_err;
        end
        if (w_rdy2) begin
            r2_px  <= n_px;
            r2_q   <= n_q;
            r2_err <= r1_err;
        end
        if (w_rdy3) begin
            r3_base <= r2_px + r2_q;
            r3_err  <= r2_err;
        end
    end

    assign o_valid = r3_v;
    assign o_base  = r3_base;
    assign o_err   = r3_err;

endmodule

// ----- rtl/b6t_emit.sv -----
// Corner register and tetrahedron sequencer that sends six results per brick.
module b6t_emit
    import b6t_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_grid              i_grid,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_node              i_base,
    input  logic               i_err,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [TETRA_W-1:0] o_tetra,
    output t_node [3:0]        o_corner,
    output logic               o_last,
    output logic               o_err
);

    logic                r_valid;
    logic [TETRA_W-1:0]  r_cnt;
    logic                r_err;
    t_node [CORNERS-1:0] r_corner, n_corner;
    logic                w_take, w_last, w_load;

    assign w_take  = r_valid && i_ready;
    assign w_last  = (r_cnt == LAST_TETRA);
    assign o_ready = !r_valid || (w_take && w_last);
    assign w_load  = i_valid && o_ready;

    always_comb begin
        for (int k = 0; k < CORNERS; k++) begin
            n_corner[k] = i_err ? '0 : (i_base + i_grid.offset[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else if (w_load) begin
            r_valid <= 1'b1;
            r_cnt   <= '0;
        end else if (w_take) begin
            if (w_last) begin
                r_valid <= 1'b0;
                r_cnt   <= '0;
            end else begin
                r_cnt <= r_cnt + TETRA_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_corner <= n_corner;
            r_err    <= i_err;
        end
    end

    always_comb begin
        for (int m = 0; m < 4; m++) begin
            o_corner[m] = r_corner[tetra_corner(r_cnt, 2'(m))];
        end
    end

    assign o_valid = r_valid;
    assign o_tetra = r_cnt;
    assign o_last  = w_last;
    assign o_err   = r_err;

endmodule

// ----- rtl/b6t_checker.sv -----
// Port-level checker of the brick to six tetrahedra block, bound to the top level.
module b6t_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [103:0] m_axis_tdata,
    input logic         m_axis_tlast,
    input logic         m_axis_tuser
);

    a_tetra_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] <= 3'd5))
        else $error("tetrahedron number above five");

    a_last_on_sixth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[2:0] == 3'd5)))
        else $error("tlast not on the sixth tetrahedron");

    a_error_zero_nodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[102:3] == 100'd0))
        else $error("node numbers not zero on a range error");

    // Within a brick the next tetrahedron follows straight after the previous one is taken.
    a_tetra_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
            (m_axis_tvalid && (m_axis_tdata[2:0] == $past(m_axis_tdata[2:0]) + 3'd1)))
        else $error("tetrahedron sequence broken within a brick");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed while stalled");

endmodule

bind brick_to_six_tetra_node_ids_core b6t_checker u_b6t_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
